FILE: rtl/core/mbrtu_pkg.sv
// Shared constants and CRC helper for the Modbus RTU request framer.
package mbrtu_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned REG_ADDR_W = 16;
    localparam int unsigned WORD_W     = 16;
    localparam int unsigned CRC_W      = 16;
    localparam int unsigned IDX_W      = 3;

    // s_tdata: op, register_address, data_word, zero fill to whole bytes
    localparam int unsigned REQ_BITS   = 1 + REG_ADDR_W + WORD_W;
    localparam int unsigned S_DATA_W   = ((REQ_BITS + 7) / 8) * 8;
    localparam int unsigned M_DATA_W   = BYTE_W;

    localparam logic [CRC_W-1:0]  CRC_POLY = 16'hA001;
    localparam logic [CRC_W-1:0]  CRC_INIT = 16'hFFFF;

    localparam logic [BYTE_W-1:0] FUNC_READ  = 8'd3;
    localparam logic [BYTE_W-1:0] FUNC_WRITE = 8'd6;

    localparam logic [BYTE_W-1:0] SLAVE_ADDR_RESET = 8'd1;

    // op codes
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // byte positions within a frame
    localparam logic [IDX_W-1:0] IDX_SLAVE   = 3'd0;
    localparam logic [IDX_W-1:0] IDX_FUNC    = 3'd1;
    localparam logic [IDX_W-1:0] IDX_ADDR_HI = 3'd2;
    localparam logic [IDX_W-1:0] IDX_ADDR_LO = 3'd3;
    localparam logic [IDX_W-1:0] IDX_WORD_HI = 3'd4;
    localparam logic [IDX_W-1:0] IDX_WORD_LO = 3'd5;
    localparam logic [IDX_W-1:0] IDX_CRC_LO  = 3'd6;
    localparam logic [IDX_W-1:0] IDX_CRC_HI  = 3'd7;

    // one byte through the reflected CRC-16/Modbus
    function automatic logic [CRC_W-1:0] crc_feed(
        input logic [CRC_W-1:0]  crc_in,
        input logic [BYTE_W-1:0] data
    );
        logic [CRC_W-1:0] c;
        c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int k = 0; k < BYTE_W; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/modbus_rtu_request_framer_unit.sv
// An accepted request goes to the request buffer, then its first frame byte to the output
// register; the eight bytes follow one per cycle while m_tready is high.
// The frame rate is set by the single byte-wide output register.
// A second request is buffered during a frame; the CRC takes one byte per unstalled cycle.
// Reset (rst_n low, async): output and request buffer empty, slave address back to 1.
// Top level: turns one read/write register request into an 8-byte Modbus RTU frame.
module modbus_rtu_request_framer_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mbrtu_pkg::BYTE_W-1:0]      cfg_data,    // slave_address
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [0] op, [16:1] register_address, [32:17] data_word, [39:33] zero
    input  logic [mbrtu_pkg::S_DATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mbrtu_pkg::M_DATA_W-1:0]    m_tdata,     // [7:0] frame_byte
    output logic                              m_tlast      // last_byte
);
    import mbrtu_pkg::*;

    logic [BYTE_W-1:0]     slave_addr_reg;

    logic                  pend_valid_reg;
    logic                  pend_op_reg;
    logic [REG_ADDR_W-1:0] pend_addr_reg;
    logic [WORD_W-1:0]     pend_word_reg;

    logic                  busy_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [5*BYTE_W-1:0]   frame_reg;
    logic [CRC_W-1:0]      crc_reg;

    logic                  out_valid_reg;
    logic [BYTE_W-1:0]     out_byte_reg;
    logic                  out_last_reg;

    logic                  out_adv;
    logic                  pend_take;
    logic                  s_accept;
    logic [BYTE_W-1:0]     cur_byte;
    logic [BYTE_W-1:0]     func_code;

    assign cfg_ready = 1'b1;

    assign out_adv   = !out_valid_reg || m_tready;
    assign pend_take = out_adv && !busy_reg && pend_valid_reg;
    assign s_tready  = !pend_valid_reg || pend_take;
    assign s_accept  = s_tvalid && s_tready;

    assign func_code = (pend_op_reg == OP_WRITE) ? FUNC_WRITE : FUNC_READ;

    always_comb
    begin
        case (idx_reg)
            IDX_FUNC:    cur_byte = frame_reg[1*BYTE_W-1:0*BYTE_W];
            IDX_ADDR_HI: cur_byte = frame_reg[2*BYTE_W-1:1*BYTE_W];
            IDX_ADDR_LO: cur_byte = frame_reg[3*BYTE_W-1:2*BYTE_W];
            IDX_WORD_HI: cur_byte = frame_reg[4*BYTE_W-1:3*BYTE_W];
            IDX_WORD_LO: cur_byte = frame_reg[5*BYTE_W-1:4*BYTE_W];
            IDX_CRC_LO:  cur_byte = crc_reg[BYTE_W-1:0];
            IDX_CRC_HI:  cur_byte = crc_reg[CRC_W-1:BYTE_W];
            default:     cur_byte = slave_addr_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_addr_reg <= SLAVE_ADDR_RESET;
        end
        else if (cfg_valid)
        begin
            slave_addr_reg <= cfg_data;
        end
    end

    // request buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            pend_valid_reg <= 1'b1;
        end
        else if (pend_take)
        begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            pend_op_reg   <= s_tdata[0];
            pend_addr_reg <= s_tdata[REG_ADDR_W:1];
            pend_word_reg <= s_tdata[REG_ADDR_W+WORD_W:REG_ADDR_W+1];
        end
    end

    // frame sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= IDX_SLAVE;
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            if (busy_reg)
            begin
                out_valid_reg <= 1'b1;
                busy_reg      <= (idx_reg != IDX_CRC_HI);
                idx_reg       <= idx_reg + 1'b1;
            end
            else if (pend_valid_reg)
            begin
                out_valid_reg <= 1'b1;
                busy_reg      <= 1'b1;
                idx_reg       <= IDX_FUNC;
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv)
        begin
            if (busy_reg)
            begin
                out_byte_reg <= cur_byte;
                out_last_reg <= (idx_reg == IDX_CRC_HI);
                if (idx_reg <= IDX_WORD_LO)
                begin
                    crc_reg <= crc_feed(crc_reg, cur_byte);
                end
            end
            else if (pend_valid_reg)
            begin
                out_byte_reg <= slave_addr_reg;
                out_last_reg <= 1'b0;
                crc_reg      <= crc_feed(CRC_INIT, slave_addr_reg);
                frame_reg    <= {pend_word_reg[BYTE_W-1:0], pend_word_reg[WORD_W-1:BYTE_W],
                                 pend_addr_reg[BYTE_W-1:0], pend_addr_reg[REG_ADDR_W-1:BYTE_W],
                                 func_code};
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: rtl/core/mbrtu_checker.sv
// Port-level checks for the request framer, bound to the top level.
module mbrtu_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [mbrtu_pkg::M_DATA_W-1:0] m_tdata,
    input logic                           m_tlast
);
    import mbrtu_pkg::*;

    logic [IDX_W-1:0] cnt_reg;
    logic             out_fire;

    assign out_fire = m_tvalid && m_tready;

    // position of the next accepted byte within its frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (out_fire)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("output valid during reset");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled frame byte changed");

    a_last_at_eight: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire |-> (m_tlast == (cnt_reg == IDX_CRC_HI)))
        else $error("tlast not on eighth byte of frame");

    a_no_double_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && m_tlast |=> !(m_tvalid && m_tlast))
        else $error("two last bytes in a row");

endmodule

bind modbus_rtu_request_framer_unit mbrtu_checker u_mbrtu_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
